### rtl/stbs_pkg.sv
package stbs_pkg;

  // Request opcodes
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_FOUND     = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_BAD_SIG   = 2'd2;

  // Register indexes (byte address / 4)
  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_ENTRY_COUNT        = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DB_SIGNATURE       = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_EXPECTED_SIGNATURE = 2'd2;

  localparam int unsigned COUNT_W = 9;

  typedef struct packed {
    logic        func;
    logic [7:0]  entry_index;
    logic [31:0] key_id;
    logic [31:0] entry_size_in;
    logic [31:0] entry_offset_in;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] entry_size;
    logic [31:0] entry_offset;
  } result_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] size;
    logic [31:0] offset;
  } entry_t;

  typedef struct packed {
    logic [COUNT_W-1:0] entry_count;
    logic [31:0]        db_signature;
    logic [31:0]        expected_signature;
  } cfg_t;

  // Controller -> datapath
  typedef struct packed {
    logic       load;        // capture request
    logic       wr;          // write entry to table
    logic       init;        // start search, issue first probe
    logic       step;        // narrow range, issue next probe
    logic       emit;        // present result
    logic [1:0] emit_status;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic func_lookup;
    logic sig_ok;
    logic count_zero;
    logic hit;           // probed id equals key
    logic range_empty;   // range after this probe holds nothing
  } dp_stat_t;

endpackage

### rtl/stbs_ram.sv
module stbs_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/stbs_regs.sv
module stbs_regs
  import stbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic                 wr_strobe;
  logic [REG_IDX_W-1:0] idx;

  assign pready    = 1'b1;
  assign wr_strobe = psel & penable & pwrite & pready;
  assign idx       = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_strobe) begin
      unique case (idx)
        REG_ENTRY_COUNT:        cfg.entry_count        <= pwdata[COUNT_W-1:0];
        REG_DB_SIGNATURE:       cfg.db_signature       <= pwdata;
        REG_EXPECTED_SIGNATURE: cfg.expected_signature <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENTRY_COUNT:        prdata = {{(32-COUNT_W){1'b0}}, cfg.entry_count};
      REG_DB_SIGNATURE:       prdata = cfg.db_signature;
      REG_EXPECTED_SIGNATURE: prdata = cfg.expected_signature;
      default:                prdata = '0;
    endcase
  end

endmodule

### rtl/stbs_ctrl.sv
module stbs_ctrl
  import stbs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE     = 3'b001,
    S_DISPATCH = 3'b010,
    S_PROBE    = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_IDLE;
        priority if (!stat.func_lookup) begin
          cmd.wr = 1'b1;
        end else if (!stat.sig_ok) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = STATUS_BAD_SIG;
        end else if (stat.count_zero) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = STATUS_NOT_FOUND;
        end else begin
          cmd.init   = 1'b1;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        priority if (stat.hit) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = STATUS_FOUND;
          state_next      = S_IDLE;
        end else if (stat.range_empty) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = STATUS_NOT_FOUND;
          state_next      = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/stbs_dpath.sv
module stbs_dpath
  import stbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic     clk,
  input  logic     rst,
  input  request_t request,
  input  cfg_t     cfg,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output logic     result_valid,
  output result_t  result
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  request_t       req_q;
  logic [CW-1:0]  lo;
  logic [CW-1:0]  hend;     // exclusive upper bound
  logic [AW-1:0]  mid;
  logic [CW-1:0]  count_sat;
  logic [CW-1:0]  lo_upd;
  logic [CW-1:0]  hend_upd;
  logic [CW:0]    sum_init;
  logic [CW:0]    sum_step;
  logic [AW-1:0]  mid_init;
  logic [AW-1:0]  mid_step;
  logic [AW-1:0]  rd_addr;
  logic [95:0]    rd_raw;
  entry_t         rd_entry;
  entry_t         wr_entry;
  logic           slot_ok;
  logic           go_up;

  always_comb begin
    if ({{(32-COUNT_W){1'b0}}, cfg.entry_count} > 32'(TABLE_DEPTH)) begin
      count_sat = CW'(TABLE_DEPTH);
    end else begin
      count_sat = CW'(cfg.entry_count);
    end
  end

  assign rd_entry = entry_t'(rd_raw);
  assign go_up    = (rd_entry.id < req_q.key_id);
  assign lo_upd   = go_up ? (CW'(mid) + CW'(1)) : lo;
  assign hend_upd = go_up ? hend : CW'(mid);

  // floor of midpoint over inclusive range [lo, hend-1]
  assign sum_init = {1'b0, count_sat} - (CW + 1)'(1);
  assign mid_init = sum_init[AW:1];
  assign sum_step = {1'b0, lo_upd} + {1'b0, hend_upd} - (CW + 1)'(1);
  assign mid_step = sum_step[AW:1];
  assign rd_addr  = cmd.init ? mid_init : mid_step;

  assign slot_ok  = ({24'd0, req_q.entry_index} < 32'(TABLE_DEPTH));
  assign wr_entry = '{id: req_q.key_id, size: req_q.entry_size_in,
                      offset: req_q.entry_offset_in};

  always_comb begin
    stat.func_lookup = (req_q.func == FUNC_LOOKUP);
    stat.sig_ok      = (cfg.db_signature == cfg.expected_signature);
    stat.count_zero  = (count_sat == '0);
    stat.hit         = (rd_entry.id == req_q.key_id);
    stat.range_empty = (lo_upd >= hend_upd);
  end

  stbs_ram #(
    .WIDTH(96),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (cmd.wr & slot_ok),
    .wr_addr(AW'(req_q.entry_index)),
    .wr_data(wr_entry),
    .rd_en  (cmd.init | cmd.step),
    .rd_addr(rd_addr),
    .rd_data(rd_raw)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= request;
    end
    if (cmd.init) begin
      lo   <= '0;
      hend <= count_sat;
      mid  <= mid_init;
    end else if (cmd.step) begin
      lo   <= lo_upd;
      hend <= hend_upd;
      mid  <= mid_step;
    end
    if (cmd.emit) begin
      result.status <= cmd.emit_status;
      if (cmd.emit_status == STATUS_FOUND) begin
        result.entry_size   <= rd_entry.size;
        result.entry_offset <= rd_entry.offset;
      end else begin
        result.entry_size   <= '0;
        result.entry_offset <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

endmodule

### rtl/sorted_table_binary_search.sv
// Sorted resource table with binary-search lookup. Entries {id, size, offset}
// are loaded one request at a time (func = write); a lookup request checks the
// header signature registers and then binary-searches slots 0..entry_count-1
// (entry_count saturated to TABLE_DEPTH) for key_id. Ids must be ascending.
// A request is taken when start is high and busy is low. A write passes
// through the dispatch state and gives no result. A lookup gives exactly one
// result, shown on result for a single cycle with result_valid high; the
// receiver cannot stall it, so it must take the result in that cycle. A bad
// signature or an empty table is answered from the dispatch state; else the
// search probes until a hit or an empty range, at most floor(log2(count)) + 1
// probes (9 at 256 entries). The table RAM has a registered read, and the
// compare on the returned id directly picks the next probe address. busy
// drops in the cycle the result is shown, so the next request can be taken
// then. Slots never written read as unknown data; the table RAM has no reset
// and no clearing pass.
// Config registers (APB, byte address 4*i): 0 entry_count, 1 db_signature,
// 2 expected_signature; write them only while the block is idle.
module sorted_table_binary_search
  import stbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        start,
  output logic        busy,
  input  request_t    request,
  // result channel
  output logic        result_valid,
  output result_t     result,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // register file
  stbs_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  // sequencer: dispatch, then one probe per cycle
  stbs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  // table RAM, search bounds, result register
  stbs_dpath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .request     (request),
    .cfg         (cfg),
    .cmd         (cmd),
    .stat        (stat),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule

### tb/sv/lookup_result_monitor.sv
`timescale 1ns / 100ps

// Watches the request, result and register ports, keeps a shadow of the
// table and registers, predicts each lookup answer and compares it.
module lookup_result_monitor
  import stbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  request_t    request,
  input  logic        result_valid,
  input  result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int unsigned fail_count,
  output int unsigned pending
);

  entry_t      entries [TABLE_DEPTH];
  logic [8:0]  count_reg;
  logic [31:0] db_sig_reg;
  logic [31:0] exp_sig_reg;
  result_t     lookup_answers [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Binary search over the shadow table, same probe order as the block.
  function automatic result_t search_table(input logic [31:0] key);
    result_t     r;
    int          lo;
    int          hi;
    int          mid;
    int unsigned n;
    bit          hit;
    r.status       = STATUS_NOT_FOUND;
    r.entry_size   = '0;
    r.entry_offset = '0;
    hit            = 1'b0;
    if (db_sig_reg != exp_sig_reg) begin
      r.status = STATUS_BAD_SIG;
    end else begin
      n  = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
      lo = 0;
      hi = int'(n) - 1;
      while (lo <= hi && !hit) begin
        mid = (lo + hi) / 2;
        if (entries[mid].id == key) begin
          r.status       = STATUS_FOUND;
          r.entry_size   = entries[mid].size;
          r.entry_offset = entries[mid].offset;
          hit            = 1'b1;
        end else if (entries[mid].id < key) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t     want;
    logic [31:0] reg_val;
    bit          mapped;
    if (rst) begin
      lookup_answers.delete();
      count_reg   = '0;
      db_sig_reg  = '0;
      exp_sig_reg = '0;
    end else begin
      // result first: a request taken on the same edge is newer
      if (result_valid) begin
        if (lookup_answers.size() == 0) begin
          $error("result with no lookup outstanding: status %0d", result.status);
          fail_count++;
        end else begin
          want = lookup_answers.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            fail_count++;
          end
          if (result.entry_size !== want.entry_size) begin
            $error("entry_size: expected %h, got %h", want.entry_size, result.entry_size);
            fail_count++;
          end
          if (result.entry_offset !== want.entry_offset) begin
            $error("entry_offset: expected %h, got %h", want.entry_offset,
                   result.entry_offset);
            fail_count++;
          end
        end
      end

      if (start && !busy) begin
        if (request.func == FUNC_WRITE) begin
          if (request.entry_index < TABLE_DEPTH) begin
            entries[request.entry_index] = '{request.key_id, request.entry_size_in,
                                             request.entry_offset_in};
          end
        end else begin
          lookup_answers.push_back(search_table(request.key_id));
        end
      end

      if (psel && penable && pready) begin
        mapped = 1'b1;
        case (paddr[3:2])
          REG_ENTRY_COUNT:        reg_val = {23'd0, count_reg};
          REG_DB_SIGNATURE:       reg_val = db_sig_reg;
          REG_EXPECTED_SIGNATURE: reg_val = exp_sig_reg;
          default:                mapped  = 1'b0;
        endcase
        if (pwrite) begin
          case (paddr[3:2])
            REG_ENTRY_COUNT:        count_reg   = pwdata[8:0];
            REG_DB_SIGNATURE:       db_sig_reg  = pwdata;
            REG_EXPECTED_SIGNATURE: exp_sig_reg = pwdata;
            default: ;
          endcase
        end else if (mapped && prdata !== reg_val) begin
          $error("prdata reg %0d: expected %h, got %h", paddr[3:2], reg_val, prdata);
          fail_count++;
        end
      end
    end
    pending = lookup_answers.size();
  end

endmodule

### tb/sv/sorted_table_binary_search_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the sorted-table search block. A directed
// opening walks the corner cases, then random table episodes follow:
// program registers while idle, load a table, then fire lookups.
module sorted_table_binary_search_tb;
  import stbs_pkg::*;

  localparam int unsigned DEPTH         = 256;
  localparam int unsigned ITEM_TARGET   = 1850;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam logic [1:0]  REG_UNMAPPED  = 2'd3;   // hole past the register map

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  request_t    request = '0;
  logic        result_valid;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent = 0;
  int unsigned idle_pct = 0;

  // ids currently loaded, used to build tables and to aim lookups at real entries
  logic [31:0] loaded_id [DEPTH];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_table_binary_search #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk, .rst, .start, .busy, .request, .result_valid, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  lookup_result_monitor #(.TABLE_DEPTH(DEPTH)) lookup_monitor (
    .clk, .rst, .start, .busy, .request, .result_valid, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_count, .pending
  );

  // Watchdog: any request, result or register access counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // start is dropped at each negedge of a gap; the only other writer is
  // send_request, so start never gets two assignments in one step.
  task automatic pause(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Idle = no lookup outstanding and enough slack for a trailing write
  // (which gives no result) to finish.
  task automatic wait_idle();
    pause(1);
    while (pending != 0) pause(1);
    pause(4);
  endtask

  // Present one request; returns on the edge that takes it (busy sampled
  // at the edge, before the block updates). Each cycle the sender could
  // present, it holds off with probability idle_pct percent.
  task automatic send_request(input request_t req);
    while ($urandom_range(0, 99) < idle_pct) pause(1);
    @(negedge clk);
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic load_entry(input logic [7:0] slot, input logic [31:0] id,
                            input logic [31:0] size, input logic [31:0] offset);
    request_t req;
    req.func            = FUNC_WRITE;
    req.entry_index     = slot;
    req.key_id          = id;
    req.entry_size_in   = size;
    req.entry_offset_in = offset;
    loaded_id[slot]     = id;
    send_request(req);
  endtask

  // Unused fields get noise: the block must ignore them on a lookup.
  task automatic lookup_id(input logic [31:0] key);
    request_t req;
    req.func            = FUNC_LOOKUP;
    req.entry_index     = 8'($urandom);
    req.key_id          = key;
    req.entry_size_in   = $urandom;
    req.entry_offset_in = $urandom;
    send_request(req);
  endtask

  // APB write: setup cycle, then access cycle (pready is tied high)
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_reg(input logic [1:0] idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Full register update, always from idle, with read-back.
  task automatic configure(input logic [8:0] count, input logic [31:0] db_sig,
                           input logic [31:0] exp_sig);
    wait_idle();
    write_reg(REG_ENTRY_COUNT, {23'd0, count});
    write_reg(REG_DB_SIGNATURE, db_sig);
    write_reg(REG_EXPECTED_SIGNATURE, exp_sig);
    read_reg(REG_ENTRY_COUNT);
    read_reg(REG_DB_SIGNATURE);
    read_reg(REG_EXPECTED_SIGNATURE);
  endtask

  // One episode: registers, then slots 0..slots-1 loaded, then lookups.
  // count_val never reaches past loaded slots, so no probe hits an
  // unwritten entry. slots = 0 reuses whatever is loaded.
  task automatic table_episode(input int unsigned slots, input logic [8:0] count_val,
                               input int unsigned lookups);
    logic [31:0] step;
    logic [31:0] cur;
    logic [31:0] sig;
    logic [31:0] db_sig;
    logic [31:0] key;
    int unsigned eff;
    int unsigned k;
    int unsigned slot;
    int unsigned r;
    bit          scramble;
    bit          downward;
    scramble = ($urandom_range(0, 9) == 0);     // unsorted table now and then
    downward = 1'($urandom_range(0, 1));
    if (slots > 0) begin
      step = 32'hFFFF_FFFF / (slots + 1);
      cur  = $urandom_range(0, step);
      for (k = 0; k < slots; k++) begin
        loaded_id[k] = scramble ? $urandom : cur;
        // occasional duplicate id
        cur = cur + (($urandom_range(0, 19) == 0) ? 32'd0 : $urandom_range(1, step));
      end
    end

    r   = $urandom_range(0, 9);
    sig = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
    db_sig = sig;
    if ($urandom_range(0, 99) < 20) begin
      db_sig = $urandom_range(0, 1) ? (sig ^ (32'h1 << $urandom_range(0, 31))) : $urandom;
    end
    configure(count_val, db_sig, sig);

    for (k = 0; k < slots; k++) begin
      slot = downward ? (slots - 1 - k) : k;
      load_entry(slot[7:0], loaded_id[slot], $urandom, $urandom);
    end

    eff = (count_val > DEPTH) ? DEPTH : count_val;
    for (k = 0; k < lookups; k++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // stray write: outside the searched range, or a same-id refresh
        if (eff < DEPTH) begin
          slot = $urandom_range(eff, DEPTH - 1);
          load_entry(slot[7:0], $urandom, $urandom, $urandom);
        end else begin
          slot = $urandom_range(0, DEPTH - 1);
          load_entry(slot[7:0], loaded_id[slot], $urandom, $urandom);
        end
      end else begin
        r = $urandom_range(0, 99);
        if (eff == 0 || r >= 80) begin
          key = $urandom;
        end else begin
          key = loaded_id[$urandom_range(0, eff - 1)];
          if (r >= 50 && r < 70) begin
            key = $urandom_range(0, 1) ? key + 32'd1 : key - 32'd1;
          end else if (r >= 70) begin
            key = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
          end
        end
        lookup_id(key);
      end
    end
  endtask

  initial begin
    int unsigned slots;
    int unsigned r;
    bit          big_done;
    big_done = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed opening ----
    // reset state: signatures both zero (match), count zero -> not found
    lookup_id(32'h0);
    lookup_id(32'hFFFF_FFFF);

    // header signature mismatch: no search at all
    configure(9'd0, 32'hDEAD_BEEF, 32'h0);
    lookup_id(32'h0);

    // good signature, four sorted entries; also poke the unmapped address
    configure(9'd4, 32'hDEAD_BEEF, 32'hDEAD_BEEF);
    wait_idle();
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    read_reg(REG_UNMAPPED);
    read_reg(REG_ENTRY_COUNT);
    load_entry(8'd0, 32'h0, 32'hFFFF_FFFF, 32'h0);
    load_entry(8'd1, 32'd5, 32'h0, 32'hFFFF_FFFF);
    load_entry(8'd2, 32'd6, 32'h1234_5678, 32'h9ABC_DEF0);
    load_entry(8'd3, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    load_entry(8'd255, 32'hFFFF_FFFF, 32'h1, 32'h2);   // top slot, not searched
    lookup_id(32'h0);            // first entry
    lookup_id(32'd5);
    lookup_id(32'd6);
    lookup_id(32'hFFFF_FFFF);    // last entry
    lookup_id(32'd3);            // gap between ids
    lookup_id(32'd7);

    // break the ordering: probe path now skips id 6
    load_entry(8'd1, 32'd100, 32'hCAFE_0001, 32'hCAFE_0002);
    lookup_id(32'd6);
    lookup_id(32'd100);

    // single-entry table
    configure(9'd1, 32'h0, 32'h0);
    lookup_id(32'h0);
    lookup_id(32'hFFFF_FFFF);

    // ---- random episodes ----
    // full table, then a count past the depth that must saturate
    idle_pct = 37;
    table_episode(DEPTH, 9'd256, 30);
    table_episode(0, 9'd511, 20);

    while (items_sent < ITEM_TARGET) begin
      // sender idle rate by phase: 37%, then 49%, then back-to-back
      if (items_sent < ITEM_TARGET / 3) begin
        idle_pct = 37;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
        idle_pct = 49;
      end else begin
        idle_pct = 0;
        if (!big_done) begin
          big_done = 1'b1;
          table_episode(DEPTH, 9'd256, 20);
        end
      end
      r     = $urandom_range(0, 99);
      slots = (r < 10) ? 0 : (r < 85) ? $urandom_range(1, 16) : $urandom_range(17, 64);
      table_episode(slots,
                    9'(($urandom_range(0, 4) == 0) ? $urandom_range(0, slots) : slots),
                    $urandom_range(4, 24));
    end

    // drain: all lookups answered, then a little slack for late strobes
    wait_idle();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
